// File: sv/matrix3_inverse_determinant_defines.svh
// Shared assertion macros for the matrix inverse block.
`ifndef MATRIX3_INVERSE_DETERMINANT_DEFINES_SVH
`define MATRIX3_INVERSE_DETERMINANT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define M3ID_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define M3ID_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/m3id_pkg.sv
package m3id_pkg;

    localparam int EW = 32;
    localparam int FB = 16;
    localparam int NLANE = 9;
    localparam int CW = 2 * EW + 1;
    localparam int PW = 2 * EW + 1;
    localparam int TW = 3 * EW + 1;
    localparam int DW = 3 * EW + 3;
    localparam int NW = CW + 2 * FB;
    localparam int QB = EW + 1;
    localparam int FRONT_LAT = 8;
    localparam int LANE_LAT = QB + 1;

    localparam logic [EW-1:0] SAT_MAX = {1'b0, {(EW-1){1'b1}}};
    localparam logic [EW-1:0] SAT_MIN = {1'b1, {(EW-1){1'b0}}};
    localparam logic [EW-1:0] ONE_CODE = (FB <= EW - 2) ? (EW'(1) << FB) : SAT_MAX;
    localparam logic ONE_OVF = (FB > EW - 2);

    // cofactor k = a[p]*a[q] - a[s]*a[t], elements row-major from 0
    localparam int COF [9][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    typedef struct packed {
        logic          singular;
        logic [EW-1:0] det_code;
        logic          det_ovf;
    } t_info;

endpackage

// File: sv/m3id_front.sv
module m3id_front (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_en,
    input  logic                                         i_valid,
    input  logic [m3id_pkg::NLANE-1:0][m3id_pkg::EW-1:0] i_a,
    output logic                                         o_valid,
    output m3id_pkg::t_info                              o_info,
    output logic [m3id_pkg::NLANE-1:0][m3id_pkg::NW-1:0] o_num,
    output logic [m3id_pkg::DW-1:0]                      o_den,
    output logic [m3id_pkg::NLANE-1:0]                   o_neg
);

    localparam int EW = m3id_pkg::EW;
    localparam int CW = m3id_pkg::CW;
    localparam int PW = m3id_pkg::PW;
    localparam int TW = m3id_pkg::TW;
    localparam int DW = m3id_pkg::DW;
    localparam int FB = m3id_pkg::FB;
    localparam int NL = m3id_pkg::NLANE;
    localparam int HW = DW - 2 * FB;

    logic [m3id_pkg::FRONT_LAT-1:0] r_vld;

    logic signed [EW-1:0]   r_a [NL];
    logic signed [2*EW-1:0] r_px [NL];
    logic signed [2*EW-1:0] r_py [NL];
    logic signed [EW-1:0]   r2_a1 [3];
    logic signed [CW-1:0]   r_c [NL];
    logic signed [EW-1:0]   r3_a1 [3];
    logic signed [PW-1:0]   r_lo [3];
    logic signed [PW-1:0]   r_hi [3];
    logic signed [TW-1:0]   r_t [3];
    logic signed [DW-1:0]   r_d;
    logic [CW-1:0]          r_cm [5][NL];
    logic                   r_cn [5][NL];
    logic [DW-1:0]          r7_dmag;
    logic                   r7_dneg;
    logic                   r7_sing;
    logic [DW-1:0]          r8_dmag;
    logic                   r8_dneg;
    m3id_pkg::t_info        r8_info;

    logic [HW-1:0]          n_dhi;
    logic                   n_dbig;
    m3id_pkg::t_info        n_info;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[m3id_pkg::FRONT_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NL; k++) begin
                r_a[k]  <= $signed(i_a[k]);
                r_px[k] <= r_a[m3id_pkg::COF[k][0]] * r_a[m3id_pkg::COF[k][1]];
                r_py[k] <= r_a[m3id_pkg::COF[k][2]] * r_a[m3id_pkg::COF[k][3]];
                r_c[k]  <= CW'(r_px[k]) - CW'(r_py[k]);
                r_cm[0][k] <= r_c[k][CW-1] ? CW'(-r_c[k]) : CW'(r_c[k]);
                r_cn[0][k] <= r_c[k][CW-1];
            end
            for (int s = 1; s < 5; s++) begin
                r_cm[s] <= r_cm[s-1];
                r_cn[s] <= r_cn[s-1];
            end
            for (int i = 0; i < 3; i++) begin
                r2_a1[i] <= r_a[i];
                r3_a1[i] <= r2_a1[i];
                r_lo[i]  <= r3_a1[i] * $signed({1'b0, r_c[3*i][EW-1:0]});
                r_hi[i]  <= r3_a1[i] * $signed(r_c[3*i][CW-1:EW]);
                r_t[i]   <= (TW'(r_hi[i]) <<< EW) + TW'(r_lo[i]);
            end
            r_d     <= DW'(r_t[0]) + DW'(r_t[1]) + DW'(r_t[2]);
            r7_dmag <= r_d[DW-1] ? DW'(-r_d) : DW'(r_d);
            r7_dneg <= r_d[DW-1];
            r7_sing <= (r_d == '0);
            r8_dmag <= r7_dmag;
            r8_dneg <= r7_dneg;
            r8_info <= n_info;
        end
    end

    always_comb begin
        n_dhi  = r7_dmag[DW-1:2*FB];
        n_dbig = r7_dneg ? (n_dhi > HW'({1'b1, {(EW-1){1'b0}}}))
                         : (n_dhi > HW'({(EW-1){1'b1}}));
        n_info.singular = r7_sing;
        n_info.det_ovf  = n_dbig;
        if (n_dbig) begin
            n_info.det_code = r7_dneg ? m3id_pkg::SAT_MIN : m3id_pkg::SAT_MAX;
        end else begin
            n_info.det_code = r7_dneg ? EW'(-n_dhi[EW-1:0]) : n_dhi[EW-1:0];
        end
    end

    always_comb begin
        for (int k = 0; k < NL; k++) begin
            o_num[k] = {r_cm[4][k], {(2*FB){1'b0}}};
            o_neg[k] = r_cn[4][k] ^ r8_dneg;
        end
    end

    assign o_den   = r8_dmag;
    assign o_info  = r8_info;
    assign o_valid = r_vld[m3id_pkg::FRONT_LAT-1];

endmodule

// File: sv/m3id_lane.sv
module m3id_lane (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [m3id_pkg::NW-1:0]   i_num,
    input  logic [m3id_pkg::DW-1:0]   i_den,
    input  logic                      i_neg,
    output logic [m3id_pkg::EW-1:0]   o_code,
    output logic                      o_ovf
);

    localparam int EW = m3id_pkg::EW;
    localparam int DW = m3id_pkg::DW;
    localparam int NW = m3id_pkg::NW;
    localparam int QB = m3id_pkg::QB;

    logic [DW-1:0] r_rem [QB+1];
    logic [QB-1:0] r_low [QB+1];
    logic [DW-1:0] r_m   [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    logic          r_neg [QB+1];
    logic          r_big [QB+1];

    logic [DW:0]   n_trial [QB];
    logic          n_ge    [QB];
    logic          n_sat;

    always_comb begin
        for (int j = 0; j < QB; j++) begin
            n_trial[j] = {r_rem[j], r_low[j][QB-1-j]};
            n_ge[j]    = n_trial[j] >= {1'b0, r_m[j]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DW'(i_num[NW-1:QB]);
            r_low[0] <= i_num[QB-1:0];
            r_m[0]   <= i_den;
            r_q[0]   <= '0;
            r_neg[0] <= i_neg;
            r_big[0] <= DW'(i_num[NW-1:QB]) >= i_den;
            for (int j = 0; j < QB; j++) begin
                r_rem[j+1] <= n_ge[j] ? DW'(n_trial[j] - {1'b0, r_m[j]}) : DW'(n_trial[j]);
                r_low[j+1] <= r_low[j];
                r_m[j+1]   <= r_m[j];
                r_q[j+1]   <= {r_q[j][QB-2:0], n_ge[j]};
                r_neg[j+1] <= r_neg[j];
                r_big[j+1] <= r_big[j];
            end
        end
    end

    always_comb begin
        n_sat = r_big[QB] || (r_neg[QB] ? (r_q[QB] > QB'({1'b1, {(EW-1){1'b0}}}))
                                        : (r_q[QB] > QB'({(EW-1){1'b1}})));
        if (n_sat) begin
            o_code = r_neg[QB] ? m3id_pkg::SAT_MIN : m3id_pkg::SAT_MAX;
        end else begin
            o_code = r_neg[QB] ? EW'(-r_q[QB][EW-1:0]) : r_q[QB][EW-1:0];
        end
        o_ovf = n_sat;
    end

endmodule

// File: sv/m3id_merge.sv
`include "matrix3_inverse_determinant_defines.svh"

module m3id_merge (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_en,
    input  logic                                         i_valid,
    input  m3id_pkg::t_info                              i_info,
    input  logic [m3id_pkg::NLANE-1:0][m3id_pkg::EW-1:0] i_code,
    input  logic [m3id_pkg::NLANE-1:0]                   i_ovf,
    output logic                                         o_valid,
    output logic [m3id_pkg::NLANE-1:0][m3id_pkg::EW-1:0] o_b,
    output logic [m3id_pkg::EW-1:0]                      o_det_value,
    output logic                                         o_singular,
    output logic                                         o_overflow
);

    localparam int LL = m3id_pkg::LANE_LAT;
    localparam int NL = m3id_pkg::NLANE;

    logic [LL-1:0]   r_dvld;
    m3id_pkg::t_info r_dinfo [LL];
    logic            r_valid;
    logic [NL-1:0][m3id_pkg::EW-1:0] r_b;
    logic [m3id_pkg::EW-1:0] r_det;
    logic            r_sing;
    logic            r_ovf;

    m3id_pkg::t_info n_info;
    logic [NL-1:0][m3id_pkg::EW-1:0] n_b;
    logic            n_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvld  <= '0;
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_dvld  <= {r_dvld[LL-2:0], i_valid};
            r_valid <= r_dvld[LL-1];
        end
    end

    always_comb begin
        n_info = r_dinfo[LL-1];
        for (int k = 0; k < NL; k++) begin
            if (n_info.singular) begin
                n_b[k] = (k % 4 == 0) ? m3id_pkg::ONE_CODE : '0;
            end else begin
                n_b[k] = i_code[k];
            end
        end
        n_ovf = n_info.singular ? m3id_pkg::ONE_OVF : (n_info.det_ovf | (|i_ovf));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dinfo[0] <= i_info;
            for (int s = 1; s < LL; s++) begin
                r_dinfo[s] <= r_dinfo[s-1];
            end
            r_b    <= n_b;
            r_det  <= n_info.singular ? '0 : n_info.det_code;
            r_sing <= n_info.singular;
            r_ovf  <= n_ovf;
        end
    end

    assign o_valid     = r_valid;
    assign o_b         = r_b;
    assign o_det_value = r_det;
    assign o_singular  = r_sing;
    assign o_overflow  = r_ovf;

    `M3ID_ASSERT_IMP(a_sing_det, r_valid && r_sing, r_det == '0 && r_ovf == m3id_pkg::ONE_OVF, "singular word with nonzero determinant or bad overflow")
    `M3ID_ASSERT_IMP(a_sing_ident, r_valid && r_sing, r_b[0] == m3id_pkg::ONE_CODE && r_b[1] == '0 && r_b[8] == m3id_pkg::ONE_CODE, "singular word is not identity")
    `M3ID_ASSERT_NXT(a_vld_adv, i_en && r_dvld[LL-1], r_valid, "finished word lost at output register")

endmodule

// File: sv/matrix3_inverse_determinant.sv
// Pipeline: 8 cofactor and determinant stages, 34 divider stages in each of nine
// restoring-divider lanes, 1 output register, from input acceptance to output valid.
// Throughput: one matrix per cycle unless stalled; one quotient bit per stage.
// The whole pipeline holds while the output word waits for i_ready.
// Reset: synchronous, active low; clears all valid bits, so no word is output after reset.
module matrix3_inverse_determinant (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_a11,
    input  logic [31:0] i_a12,
    input  logic [31:0] i_a13,
    input  logic [31:0] i_a21,
    input  logic [31:0] i_a22,
    input  logic [31:0] i_a23,
    input  logic [31:0] i_a31,
    input  logic [31:0] i_a32,
    input  logic [31:0] i_a33,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_b11,
    output logic [31:0] o_b12,
    output logic [31:0] o_b13,
    output logic [31:0] o_b21,
    output logic [31:0] o_b22,
    output logic [31:0] o_b23,
    output logic [31:0] o_b31,
    output logic [31:0] o_b32,
    output logic [31:0] o_b33,
    output logic [31:0] o_det_value,
    output logic        o_singular,
    output logic        o_overflow
);

    localparam int NL = m3id_pkg::NLANE;

    logic                                        w_en;
    logic [NL-1:0][m3id_pkg::EW-1:0]             w_a;
    logic                                        w_fvld;
    m3id_pkg::t_info                             w_info;
    logic [NL-1:0][m3id_pkg::NW-1:0]             w_num;
    logic [m3id_pkg::DW-1:0]                     w_den;
    logic [NL-1:0]                               w_neg;
    logic [NL-1:0][m3id_pkg::EW-1:0]             w_code;
    logic [NL-1:0]                               w_ovf;
    logic [NL-1:0][m3id_pkg::EW-1:0]             w_b;

    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    assign w_a = {i_a33, i_a32, i_a31, i_a23, i_a22, i_a21, i_a13, i_a12, i_a11};

    m3id_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_a     (w_a),
        .o_valid (w_fvld),
        .o_info  (w_info),
        .o_num   (w_num),
        .o_den   (w_den),
        .o_neg   (w_neg)
    );

    for (genvar k = 0; k < NL; k++) begin : g_lane
        m3id_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_num  (w_num[k]),
            .i_den  (w_den),
            .i_neg  (w_neg[k]),
            .o_code (w_code[k]),
            .o_ovf  (w_ovf[k])
        );
    end

    m3id_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (w_fvld),
        .i_info      (w_info),
        .i_code      (w_code),
        .i_ovf       (w_ovf),
        .o_valid     (o_valid),
        .o_b         (w_b),
        .o_det_value (o_det_value),
        .o_singular  (o_singular),
        .o_overflow  (o_overflow)
    );

    assign o_b11 = w_b[0];
    assign o_b12 = w_b[1];
    assign o_b13 = w_b[2];
    assign o_b21 = w_b[3];
    assign o_b22 = w_b[4];
    assign o_b23 = w_b[5];
    assign o_b31 = w_b[6];
    assign o_b32 = w_b[7];
    assign o_b33 = w_b[8];

endmodule

// File: tb/tb_matrix3_inverse_determinant.sv
module tb_matrix3_inverse_determinant;

    typedef struct packed {
        logic [8:0][31:0] a;
    } t_mat;

    typedef struct packed {
        logic [8:0][31:0] b;
        logic [31:0]      det;
        logic             sing;
        logic             ovf;
    } t_inv;

    localparam int N_RAND   = 1880;
    localparam int PAUSE_AT = 900;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic o_ready, o_valid, o_singular, o_overflow;
    logic [31:0] i_a [9] = '{default: '0};
    logic [31:0] o_b [9];
    logic [31:0] o_det_value;

    t_mat cur = '0;
    t_mat pending [$];
    t_inv inv_exp [$];
    int   errs = 0;
    int   n_sent = 0;
    int   n_recv = 0;
    int   n_sing = 0;
    int   n_ovf = 0;
    int   gap_cnt = 0;
    int   stall_cnt = 0;
    bit   quiet = 1'b0;
    bit   pause_done = 1'b0;

    matrix3_inverse_determinant dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_a11(i_a[0]), .i_a12(i_a[1]), .i_a13(i_a[2]),
        .i_a21(i_a[3]), .i_a22(i_a[4]), .i_a23(i_a[5]),
        .i_a31(i_a[6]), .i_a32(i_a[7]), .i_a33(i_a[8]),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_b11(o_b[0]), .o_b12(o_b[1]), .o_b13(o_b[2]),
        .o_b21(o_b[3]), .o_b22(o_b[4]), .o_b23(o_b[5]),
        .o_b31(o_b[6]), .o_b32(o_b[7]), .o_b33(o_b[8]),
        .o_det_value(o_det_value), .o_singular(o_singular), .o_overflow(o_overflow)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [31:0] sat_code(logic signed [127:0] mg, logic neg,
                                             inout logic ovf);
        logic signed [127:0] lim;
        lim = neg ? (128'sd1 <<< 31) : ((128'sd1 <<< 31) - 1);
        if (mg > lim) begin
            mg = lim;
            ovf = 1'b1;
        end
        return neg ? (32'd0 - mg[31:0]) : mg[31:0];
    endfunction

    function automatic t_inv inv_predict(t_mat m);
        logic signed [127:0] e [9];
        logic signed [127:0] c [9];
        logic signed [127:0] d, dm, mg, q;
        logic dn, cn;
        t_inv r;
        r = '0;
        for (int i = 0; i < 9; i++) e[i] = $signed(m.a[i]);
        for (int k = 0; k < 9; k++)
            c[k] = e[m3id_pkg::COF[k][0]] * e[m3id_pkg::COF[k][1]]
                 - e[m3id_pkg::COF[k][2]] * e[m3id_pkg::COF[k][3]];
        d = e[0] * c[0] + e[1] * c[3] + e[2] * c[6];
        if (d == 0) begin
            for (int i = 0; i < 9; i++) r.b[i] = (i % 4 == 0) ? m3id_pkg::ONE_CODE : '0;
            r.sing = 1'b1;
            r.ovf = m3id_pkg::ONE_OVF;
            return r;
        end
        dn = d < 0;
        dm = dn ? -d : d;
        for (int k = 0; k < 9; k++) begin
            cn = c[k] < 0;
            mg = cn ? -c[k] : c[k];
            q = (mg <<< (2 * m3id_pkg::FB)) / dm;
            r.b[k] = sat_code(q, cn ^ dn, r.ovf);
        end
        r.det = sat_code(dm >>> (2 * m3id_pkg::FB), dn, r.ovf);
        return r;
    endfunction

    function automatic logic [31:0] rnd_elem();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(262143)) - 131072);
            2: return 32'($signed($urandom_range(8388607)) - 4194304);
            3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            4: return 32'($signed($urandom_range(511)) - 256) <<< 16;
            default: return $urandom_range(3);
        endcase
    endfunction

    function automatic t_mat diag(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_mat m;
        m = '0;
        m.a[0] = x;
        m.a[4] = y;
        m.a[8] = z;
        return m;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && !o_ready)) begin
            if (i_valid) begin
                inv_exp.push_back(inv_predict(cur));
                n_sent++;
            end
            if (n_sent >= PAUSE_AT && !pause_done && inv_exp.size() == 0)
                pause_done = 1'b1;
            if (gap_cnt > 0) begin
                gap_cnt--;
                i_valid <= 1'b0;
            end else if (n_sent >= PAUSE_AT && !pause_done) begin
                i_valid <= 1'b0;
            end else if (pending.size() > 0) begin
                cur = pending.pop_front();
                for (int i = 0; i < 9; i++) i_a[i] <= cur.a[i];
                i_valid <= 1'b1;
                quiet = pending.size() < 150;
                if (!quiet && $urandom_range(3) == 0) gap_cnt = $urandom_range(7, 1);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_inv x;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                n_recv++;
                if (inv_exp.size() == 0) begin
                    $error("unexpected output word");
                    errs++;
                end else begin
                    x = inv_exp.pop_front();
                    n_sing += x.sing;
                    n_ovf += x.ovf;
                    for (int i = 0; i < 9; i++)
                        if (o_b[i] !== x.b[i]) begin
                            $error("b%0d%0d: expected %h, got %h", i / 3 + 1, i % 3 + 1,
                                   x.b[i], o_b[i]);
                            errs++;
                        end
                    if (o_det_value !== x.det) begin
                        $error("det_value: expected %h, got %h", x.det, o_det_value);
                        errs++;
                    end
                    if (o_singular !== x.sing) begin
                        $error("singular: expected %b, got %b", x.sing, o_singular);
                        errs++;
                    end
                    if (o_overflow !== x.ovf) begin
                        $error("overflow: expected %b, got %b", x.ovf, o_overflow);
                        errs++;
                    end
                end
            end
            if (stall_cnt > 0) begin
                stall_cnt--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (!quiet && $urandom_range(3) == 0) stall_cnt = $urandom_range(7, 1);
            end
        end
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        t_mat m;
        pending.push_back(diag(32'h10000, 32'h10000, 32'h10000));
        pending.push_back('0);
        pending.push_back({9{32'h7fffffff}});
        pending.push_back({9{32'h80000000}});
        pending.push_back(diag(32'h80000000, 32'h80000000, 32'h80000000));
        pending.push_back(diag(32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        pending.push_back(diag(32'h80000000, 32'h7fffffff, 32'h80000000));
        pending.push_back(diag(32'd1, 32'd1, 32'd1));
        pending.push_back(diag(32'hffffffff, 32'd1, 32'd1));
        pending.push_back(diag(32'h20000, 32'hfffe0000, 32'h8000));
        pending.push_back(diag(32'h100, 32'h100, 32'h100));
        for (int j = 0; j < 6; j++) begin
            for (int i = 0; i < 9; i++) m.a[i] = (j[0] ^ (i % 2 == 0)) ? 32'h80000000
                                                                      : 32'h7fffffff;
            if (j > 1) m.a[j] = 32'hffffffff;
            pending.push_back(m);
        end
        for (int j = 0; j < 6; j++) begin
            for (int i = 0; i < 9; i++) m.a[i] = rnd_elem();
            m.a[6 + j % 3] = m.a[j % 3];
            for (int i = 0; i < 3; i++) m.a[6 + i] = m.a[3 * (j % 2) + i];
            pending.push_back(m);
        end
        for (int n = 0; n < N_RAND; n++) begin
            for (int i = 0; i < 9; i++) m.a[i] = rnd_elem();
            case ($urandom_range(7))
                0: for (int i = 0; i < 3; i++) m.a[6 + i] = m.a[3 * $urandom_range(1) + i];
                1: for (int i = 0; i < 9; i++) if (i % 4 != 0) m.a[i] = '0;
                2: for (int i = 0; i < 9; i++) m.a[i] = $urandom;
                default: ;
            endcase
            pending.push_back(m);
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending.size() != 0 || i_valid) @(posedge i_clk);
        while (inv_exp.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        errs += inv_exp.size();
        $display("sent %0d matrices, checked %0d inverses", n_sent, n_recv);
        $display("singular cases %0d, saturated cases %0d", n_sing, n_ovf);
        if (errs == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
